@@ src/hcbp_pkg.sv @@
// ----------------------------------------------------------------------------
// hcbp_pkg
// Shared types and constants of the code table and bit packer.
// ----------------------------------------------------------------------------
`default_nettype none

package hcbp_pkg;

    localparam int BYTE_W    = 8;
    localparam int SYMBOL_W  = 8;
    localparam int CODE_IN_W = 32;
    localparam int LEN_IN_W  = 6;
    localparam int CMD_W     = 2;
    localparam int PEND_W    = 7;
    localparam int CNT_W     = 3;
    // symbol, code_bits, code_len packed and padded to whole bytes
    localparam int S_TDATA_W = 48;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD   = 2'd0,
        CMD_ENCODE = 2'd1,
        CMD_FLUSH  = 2'd2
    } cmd_t;

    // controller to datapath
    typedef struct packed {
        logic take;    // input item accepted this cycle
        logic merge;   // table word is ready, join it to the pending bits
        logic emit;    // move one byte into the output register
        logic settle;  // keep the leftover bits, item done
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        cmd_t in_cmd;
        logic ge8;       // a whole byte is in the accumulator
        logic out_free;  // output register can take a byte
    } dp_status_t;

endpackage

`default_nettype wire

@@ src/hcbp_ctrl.sv @@
// ----------------------------------------------------------------------------
// hcbp_ctrl
// Sequencer: accept an item, look up the table, emit bytes, settle.
// ----------------------------------------------------------------------------
`default_nettype none

module hcbp_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire hcbp_pkg::dp_status_t status,
    output hcbp_pkg::ctrl_cmd_t      cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        in_ready   = (state_reg == ST_IDLE);
        cmd.take   = in_ready && in_valid;
        cmd.merge  = (state_reg == ST_LOOKUP);
        cmd.emit   = (state_reg == ST_EMIT) && status.ge8 && status.out_free;
        cmd.settle = (state_reg == ST_EMIT) && !status.ge8;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.take)
                begin
                    unique case (status.in_cmd)
                        hcbp_pkg::CMD_ENCODE: state_next = ST_LOOKUP;
                        hcbp_pkg::CMD_FLUSH:  state_next = ST_EMIT;
                        default:              state_next = ST_IDLE;
                    endcase
                end
            end
            ST_LOOKUP:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (cmd.settle)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

@@ src/hcbp_datapath.sv @@
// ----------------------------------------------------------------------------
// hcbp_datapath
// Code table memories, bit accumulator and output byte register.
// ----------------------------------------------------------------------------
`default_nettype none

module hcbp_datapath #(
    parameter int NUM_SYMBOLS  = 256,
    parameter int MAX_CODE_LEN = 32
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic [hcbp_pkg::CMD_W-1:0]         in_cmd,
    input  wire logic [hcbp_pkg::SYMBOL_W-1:0]      in_symbol,
    input  wire logic [hcbp_pkg::CODE_IN_W-1:0]     in_code_bits,
    input  wire logic [hcbp_pkg::LEN_IN_W-1:0]      in_code_len,
    input  wire hcbp_pkg::ctrl_cmd_t                cmd,
    output hcbp_pkg::dp_status_t                    status,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic [hcbp_pkg::BYTE_W-1:0]             out_byte,
    output logic                                    out_last
);

    localparam int LEN_LIMIT = (MAX_CODE_LEN < hcbp_pkg::CODE_IN_W) ?
                               MAX_CODE_LEN : hcbp_pkg::CODE_IN_W;
    localparam int CODE_W = LEN_LIMIT;
    localparam int LEN_W  = $clog2(LEN_LIMIT + 1);
    localparam int ACC_W  = CODE_W + hcbp_pkg::PEND_W;
    localparam int TOT_W  = $clog2(ACC_W + 1);
    localparam int IDX_W  = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;

    logic [CODE_W-1:0] code_mem [NUM_SYMBOLS];
    logic [LEN_W-1:0]  len_mem  [NUM_SYMBOLS];
    logic              valid_reg [NUM_SYMBOLS];

    logic [CODE_W-1:0]          rd_code_reg;
    logic [LEN_W-1:0]           rd_len_reg;
    logic                       rd_hit_reg;
    logic [ACC_W-1:0]           acc_reg;
    logic [TOT_W-1:0]           total_reg;
    logic [hcbp_pkg::PEND_W-1:0] pend_bits_reg;
    logic [hcbp_pkg::CNT_W-1:0]  pend_cnt_reg;
    logic                       out_valid_reg;
    logic [hcbp_pkg::BYTE_W-1:0] out_byte_reg;
    logic                       out_last_reg;

    hcbp_pkg::cmd_t              op;
    logic                        in_range;
    logic [IDX_W-1:0]            idx;
    logic [LEN_W-1:0]            len_sat;
    logic [CODE_W-1:0]           load_mask;
    logic                        do_load;
    logic [LEN_W-1:0]            clen;
    logic [CODE_W-1:0]           ccode;
    logic [ACC_W-1:0]            merge_acc;
    logic [TOT_W-1:0]            merge_total;
    logic [hcbp_pkg::BYTE_W-1:0] flush_byte;
    logic [TOT_W-1:0]            shamt;
    logic [hcbp_pkg::BYTE_W-1:0] emit_byte;
    logic [hcbp_pkg::BYTE_W-1:0] keep_mask;

    always_comb
    begin
        op       = hcbp_pkg::cmd_t'(in_cmd);
        in_range = ({1'b0, in_symbol} < (hcbp_pkg::SYMBOL_W + 1)'(NUM_SYMBOLS));
        idx      = IDX_W'(in_symbol);
        // lengths above the table limit saturate
        if ({1'b0, in_code_len} > (hcbp_pkg::LEN_IN_W + 1)'(LEN_LIMIT))
        begin
            len_sat = LEN_W'(LEN_LIMIT);
        end
        else
        begin
            len_sat = LEN_W'(in_code_len);
        end
        for (int i = 0; i < CODE_W; i++)
        begin
            load_mask[i] = (i < int'(len_sat));
        end
        do_load = cmd.take && (op == hcbp_pkg::CMD_LOAD) && in_range;

        // a miss acts as a zero-length code and leaves the pending bits alone
        clen        = rd_hit_reg ? rd_len_reg : '0;
        ccode       = (rd_hit_reg && (rd_len_reg != '0)) ? rd_code_reg : '0;
        merge_acc   = (ACC_W'(pend_bits_reg) << clen) | ACC_W'(ccode);
        merge_total = TOT_W'(pend_cnt_reg) + TOT_W'(clen);

        flush_byte = hcbp_pkg::BYTE_W'({1'b0, pend_bits_reg} <<
                     (4'd8 - {1'b0, pend_cnt_reg}));

        shamt     = total_reg - TOT_W'(hcbp_pkg::BYTE_W);
        emit_byte = hcbp_pkg::BYTE_W'(acc_reg >> shamt);
        keep_mask = (hcbp_pkg::BYTE_W'(1) << total_reg[hcbp_pkg::CNT_W-1:0]) - 8'd1;

        status.in_cmd   = op;
        status.ge8      = (total_reg >= TOT_W'(hcbp_pkg::BYTE_W));
        status.out_free = !out_valid_reg || out_ready;
    end

    // table memories, no reset
    always_ff @(posedge clk)
    begin
        if (do_load)
        begin
            code_mem[idx] <= in_code_bits[CODE_W-1:0] & load_mask;
            len_mem[idx]  <= len_sat;
        end
        if (cmd.take)
        begin
            rd_code_reg <= code_mem[idx];
            rd_len_reg  <= len_mem[idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_SYMBOLS; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else if (do_load)
        begin
            valid_reg[idx] <= 1'b1;
        end
    end

    // working registers of the current item
    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            rd_hit_reg <= in_range && valid_reg[idx];
            acc_reg    <= ACC_W'(flush_byte);
            total_reg  <= (pend_cnt_reg != '0) ? TOT_W'(hcbp_pkg::BYTE_W) : '0;
        end
        else if (cmd.merge)
        begin
            acc_reg   <= merge_acc;
            total_reg <= merge_total;
        end
        else if (cmd.emit)
        begin
            total_reg <= shamt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_bits_reg <= '0;
            pend_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.settle)
            begin
                pend_cnt_reg  <= total_reg[hcbp_pkg::CNT_W-1:0];
                pend_bits_reg <= acc_reg[hcbp_pkg::PEND_W-1:0] &
                                 keep_mask[hcbp_pkg::PEND_W-1:0];
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_byte_reg <= emit_byte;
            // last byte when fewer than eight bits remain after this one
            out_last_reg <= (shamt < TOT_W'(hcbp_pkg::BYTE_W));
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_last  = out_last_reg;

endmodule

`default_nettype wire

@@ src/huffman_code_bit_packer.sv @@
// ----------------------------------------------------------------------------
// huffman_code_bit_packer
// Code table and MSB-first bit packer of a Huffman encoder back end.
// ----------------------------------------------------------------------------
// Input channel s_*: tuser carries the command (load, encode, flush), tdata
// the symbol, code word and code length. Output channel m_*: packed bytes,
// tlast set on the last byte caused by an input item.
// One input item is worked on at a time; s_tready is high only while idle.
// Load and unused commands finish in their accept step. Encode steps
// through accept, registered table read, one cycle per byte (0 to 4 output
// bytes) through the byte extractor while the output register is free, and
// one step to store the leftover bits. Flush emits a partial byte, if any,
// then empties the pending bits. The first byte of an encode item reaches
// m_tdata through the table read, the accumulator and the output register.
// Reset clears the pending bits and the valid bit of every table entry, so
// all lengths read as zero at once; there is no clearing pass.
// When m_tready is low the output register holds its byte and the packer
// waits in its emit step; no byte is dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module huffman_code_bit_packer #(
    parameter int NUM_SYMBOLS  = 256,
    parameter int MAX_CODE_LEN = 32
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // symbol [7:0], code_bits [39:8], code_len [45:40], zero [47:46]
    input  wire logic [hcbp_pkg::S_TDATA_W-1:0]     s_tdata,
    // command [1:0]
    input  wire logic [hcbp_pkg::CMD_W-1:0]         s_tuser,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // out_byte [7:0]
    output logic [hcbp_pkg::BYTE_W-1:0]             m_tdata,
    output logic                                    m_tlast
);

    hcbp_pkg::ctrl_cmd_t  ctrl_cmd;
    hcbp_pkg::dp_status_t dp_status;

    hcbp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (dp_status),
        .cmd      (ctrl_cmd)
    );

    hcbp_datapath #(
        .NUM_SYMBOLS  (NUM_SYMBOLS),
        .MAX_CODE_LEN (MAX_CODE_LEN)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_cmd       (s_tuser),
        .in_symbol    (s_tdata[7:0]),
        .in_code_bits (s_tdata[39:8]),
        .in_code_len  (s_tdata[45:40]),
        .cmd          (ctrl_cmd),
        .status       (dp_status),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_byte     (m_tdata),
        .out_last     (m_tlast)
    );

    // a load finishes in its own cycle
    a_load_single_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && (s_tuser == hcbp_pkg::CMD_LOAD)) |=> s_tready)
        else $error("load item did not complete in one cycle");

    // an encode item blocks the input for its table read
    a_encode_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && (s_tuser == hcbp_pkg::CMD_ENCODE)) |=> !s_tready)
        else $error("input accepted during table lookup");

    // a new byte never overwrites a stalled one
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl_cmd.emit |-> (!m_tvalid || m_tready))
        else $error("byte emitted into a full output register");

endmodule

`default_nettype wire
